// ----- hdl/tclw_pkg.sv -----
// shared types, constants and register codes for the thruster command link watchdog
package tclw_pkg;

  // channel limits
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned DefChannels = 8;
  localparam int unsigned ChIdxW      = 3;

  // field widths
  localparam int unsigned PulseW = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  // operation codes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpByte  = 2'd1;
  localparam logic [1:0] OpEnd   = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCommandCode  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLinkTimeout  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCtrlPeriod   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlowBlink    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFastBlink    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPulseMin     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPulseMax     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegFailsafe     = 3'd7;

  // register reset values
  localparam logic [7:0]  DefCommandCode = 8'h00;
  localparam logic [11:0] DefLinkTimeout = 12'd2000;
  localparam logic [7:0]  DefCtrlPeriod  = 8'd20;
  localparam logic [9:0]  DefSlowBlink   = 10'd500;
  localparam logic [9:0]  DefFastBlink   = 10'd120;
  localparam logic [11:0] DefPulseMin    = 12'd1100;
  localparam logic [11:0] DefPulseMax    = 12'd1900;
  localparam logic [7:0]  DefFailsafe    = 8'd128;

  // state reset values and limits
  localparam logic [7:0]        ThrustReset  = 8'd128;
  localparam logic [PulseW-1:0] PulseReset   = 12'd1501;
  localparam logic [2:0]        FlashToggles = 3'd4;
  localparam logic [11:0]       PktTimerMax  = 12'hFFF;
  localparam logic [7:0]        CtrlTimerMax = 8'hFF;
  localparam logic [9:0]        TogTimerMax  = 10'h3FF;
  localparam logic [CountW-1:0] CountMax     = 4'hF;

  // input beat
  typedef struct packed {
    logic [1:0]       operation;
    logic [ByteW-1:0] data_byte;
  } in_t;

  // output beat
  typedef struct packed {
    logic [PulseW-1:0] width_ch0;
    logic [PulseW-1:0] width_ch1;
    logic [PulseW-1:0] width_ch2;
    logic [PulseW-1:0] width_ch3;
    logic [PulseW-1:0] width_ch4;
    logic [PulseW-1:0] width_ch5;
    logic [PulseW-1:0] width_ch6;
    logic [PulseW-1:0] width_ch7;
    logic              led_on;
    logic              link_lost;
  } out_t;

  // request into the shared width mapper
  typedef struct packed {
    logic              valid;
    logic [ChIdxW-1:0] ch;
    logic [ByteW-1:0]  thrust;
  } map_req_t;

  // response from the shared width mapper
  typedef struct packed {
    logic              valid;
    logic [ChIdxW-1:0] ch;
    logic [PulseW-1:0] width;
  } map_rsp_t;

endpackage

// ----- hdl/tclw_mapper.sv -----
// three-stage shared mapper: thrust byte to pulse width, min +/- v*|max-min|/255
module tclw_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tclw_pkg::map_req_t           req_i,
  input  logic [tclw_pkg::PulseW-1:0]  pulse_min_i,
  input  logic [tclw_pkg::PulseW-1:0]  pulse_max_i,
  output tclw_pkg::map_rsp_t           rsp_o
);
  import tclw_pkg::*;

  localparam int unsigned ProdW  = ByteW + PulseW;
  localparam int unsigned ScaleW = ProdW + 9;

  // stage registers
  logic              v1_q, v2_q, v3_q;
  logic [ChIdxW-1:0] ch1_q, ch2_q, ch3_q;
  logic              dn1_q, dn2_q;
  logic [ProdW-1:0]  p1_q, p2_q;
  logic [PulseW-1:0] q2_q;
  logic [PulseW-1:0] w3_q;

  logic              dn1_d;
  logic [PulseW-1:0] span;
  logic [ProdW-1:0]  p1_d;
  logic [ScaleW-1:0] scaled;
  logic [PulseW-1:0] q2_d;
  logic [ProdW-1:0]  q255;
  logic [ProdW-1:0]  rem;
  logic [PulseW-1:0] qf;
  logic [PulseW-1:0] w3_d;

  // stage 1: span and product
  always_comb begin
    dn1_d = pulse_max_i < pulse_min_i;
    span  = dn1_d ? (pulse_min_i - pulse_max_i) : (pulse_max_i - pulse_min_i);
    p1_d  = ProdW'(req_i.thrust) * ProdW'(span);
  end

  // stage 2: quotient estimate via 257/65536, never above the true value
  always_comb begin
    scaled = {1'b0, p1_q, 8'b0} + ScaleW'(p1_q);
    q2_d   = PulseW'(scaled >> 16);
  end

  // stage 3: one-step correction and final offset
  always_comb begin
    q255 = {q2_q, 8'b0} - ProdW'(q2_q);
    rem  = p2_q - q255;
    qf   = q2_q + PulseW'(rem >= ProdW'(255));
    w3_d = dn2_q ? (pulse_min_i - qf) : (pulse_min_i + qf);
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // data pipe
  always_ff @(posedge clk_i) begin
    ch1_q <= req_i.ch;
    dn1_q <= dn1_d;
    p1_q  <= p1_d;
    ch2_q <= ch1_q;
    dn2_q <= dn1_q;
    p2_q  <= p1_q;
    q2_q  <= q2_d;
    ch3_q <= ch2_q;
    w3_q  <= w3_d;
  end

  assign rsp_o.valid = v3_q;
  assign rsp_o.ch    = ch3_q;
  assign rsp_o.width = w3_q;

endmodule

// ----- hdl/thruster_command_link_watchdog.sv -----
// top level of the thruster command link watchdog: packet intake, timers, led and sequencer
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+---------------------------------
//  in       | in        | in_valid_i / in_stall_o | tclw_pkg::in_t (operation, byte)
//  out      | out       | out_valid_o/ out_stall_i| tclw_pkg::out_t (widths, led, lost)
//  cfg      | in        | cfg_valid_i/ cfg_ready_o| register index and write data
//
// a byte, transaction end, unused code or tick that remaps nothing goes from idle straight to the emit state
// a tick that remaps channels passes through the map and drain states: the sequencer feeds the
// shared three-stage mapper one channel per cycle and then waits for it to drain
// in_stall_o is high from the accept until the result is loaded into the output register
// the output register holds one beat, so a new item is taken while it waits on out_stall_i
// reset restores every register default, thrust bytes 128 and widths 1501
module thruster_command_link_watchdog #(
  parameter int unsigned CHANNELS = tclw_pkg::DefChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tclw_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tclw_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tclw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tclw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tclw_pkg::*;

  localparam int unsigned PktLen = CHANNELS + 1;
  localparam int unsigned StW    = $clog2(PktLen);
  localparam int unsigned ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CntW   = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // configuration registers
  logic [7:0]  cmd_q, cmd_d;
  logic [11:0] timeout_q, timeout_d;
  logic [7:0]  period_q, period_d;
  logic [9:0]  slow_q, slow_d;
  logic [9:0]  fast_q, fast_d;
  logic [11:0] pmin_q, pmin_d;
  logic [11:0] pmax_q, pmax_d;
  logic [7:0]  fsafe_q, fsafe_d;

  // block state
  state_e            state_q, state_d;
  logic [7:0]        thrust_q [CHANNELS];
  logic [7:0]        thrust_d [CHANNELS];
  logic [PulseW-1:0] pulse_q [CHANNELS];
  logic [PulseW-1:0] pulse_d [CHANNELS];
  logic [7:0]        store_q [PktLen];
  logic [CountW-1:0] count_q, count_d;
  logic              fresh_q, fresh_d;
  logic              flash_q, flash_d;
  logic [2:0]        tl_q, tl_d;
  logic              led_q, led_d;
  logic [11:0]       pkt_q, pkt_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [9:0]        tog_q, tog_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  // datapath helpers
  logic              in_acc;
  logic              cfg_we;
  logic              store_we;
  logic [11:0]       pkt_inc;
  logic [7:0]        ctrl_inc;
  logic [9:0]        tog_inc;
  logic              ctrl_due;
  logic              alive;
  logic [2:0]        tl_f;
  logic [9:0]        tog_f;
  logic [2:0]        tl_u;
  logic [9:0]        tog_u;
  logic              led_u;
  logic              pkt_ok;
  logic [PulseW-1:0] wv [MaxChannels];
  map_req_t          req;
  map_rsp_t          rsp;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // saturating timers after one tick
  always_comb begin
    pkt_inc  = (pkt_q < PktTimerMax) ? pkt_q + 12'd1 : pkt_q;
    ctrl_inc = (ctrl_q < CtrlTimerMax) ? ctrl_q + 8'd1 : ctrl_q;
    tog_inc  = (tog_q < TogTimerMax) ? tog_q + 10'd1 : tog_q;
    ctrl_due = ctrl_inc >= period_q;
    alive    = pkt_inc <= timeout_q;
  end

  // led update of one control period
  always_comb begin
    tl_f  = flash_q ? FlashToggles : tl_q;
    tog_f = flash_q ? 10'd0 : tog_inc;
    tl_u  = tl_f;
    tog_u = tog_f;
    led_u = led_q;
    if (tl_f != 3'd0) begin
      if (tog_f >= fast_q) begin
        tog_u = 10'd0;
        led_u = !led_q;
        tl_u  = tl_f - 3'd1;
      end
    end else if (alive) begin
      if (tog_f >= slow_q) begin
        tog_u = 10'd0;
        led_u = !led_q;
      end
    end else begin
      led_u = 1'b0;
    end
  end

  // packet check at transaction end
  assign pkt_ok   = (count_q == CountW'(PktLen)) && (store_q[0] == cmd_q);
  assign store_we = in_acc && (in_data_i.operation == OpByte) && (count_q < CountW'(PktLen));

  // current widths padded to the full channel set
  always_comb begin
    for (int i = 0; i < MaxChannels; i++) begin
      wv[i] = '0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      wv[i] = pulse_q[i];
    end
  end

  // next-state logic
  always_comb begin
    cmd_d       = cmd_q;
    timeout_d   = timeout_q;
    period_d    = period_q;
    slow_d      = slow_q;
    fast_d      = fast_q;
    pmin_d      = pmin_q;
    pmax_d      = pmax_q;
    fsafe_d     = fsafe_q;
    state_d     = state_q;
    thrust_d    = thrust_q;
    pulse_d     = pulse_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    flash_d     = flash_q;
    tl_d        = tl_q;
    led_d       = led_q;
    pkt_d       = pkt_q;
    ctrl_d      = ctrl_q;
    tog_d       = tog_q;
    issue_d     = issue_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req.valid   = 1'b0;
    req.ch      = ChIdxW'(issue_q);
    req.thrust  = thrust_q[issue_q[ChW-1:0]];

    // register writes
    if (cfg_we) begin
      unique case (cfg_index_i)
        RegCommandCode: cmd_d     = cfg_data_i[7:0];
        RegLinkTimeout: timeout_d = cfg_data_i[11:0];
        RegCtrlPeriod:  period_d  = cfg_data_i[7:0];
        RegSlowBlink:   slow_d    = cfg_data_i[9:0];
        RegFastBlink:   fast_d    = cfg_data_i[9:0];
        RegPulseMin:    pmin_d    = cfg_data_i[11:0];
        RegPulseMax:    pmax_d    = cfg_data_i[11:0];
        RegFailsafe:    fsafe_d   = cfg_data_i[7:0];
        default: ;
      endcase
    end

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // mapper results land in the width registers
    for (int i = 0; i < CHANNELS; i++) begin
      if (rsp.valid && rsp.ch == ChIdxW'(i)) begin
        pulse_d[i] = rsp.width;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EMIT;
          case (in_data_i.operation)
            OpTick: begin
              pkt_d  = pkt_inc;
              ctrl_d = ctrl_inc;
              tog_d  = tog_inc;
              if (ctrl_due) begin
                ctrl_d  = 8'd0;
                flash_d = 1'b0;
                tl_d    = tl_u;
                tog_d   = tog_u;
                led_d   = led_u;
                issue_d = '0;
                if (!alive) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                    thrust_d[i] = fsafe_q;
                  end
                  state_d = ST_MAP;
                end else if (fresh_q) begin
                  fresh_d = 1'b0;
                  state_d = ST_MAP;
                end
              end
            end
            OpByte: begin
              if (count_q < CountMax) begin
                count_d = count_q + CountW'(1);
              end
            end
            OpEnd: begin
              if (pkt_ok) begin
                for (int i = 0; i < CHANNELS; i++) begin
                  thrust_d[i] = store_q[i + 1];
                end
                fresh_d = 1'b1;
                flash_d = 1'b1;
                pkt_d   = 12'd0;
              end
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MAP: begin
        req.valid = 1'b1;
        if (issue_q == CntW'(CHANNELS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          issue_d = issue_q + CntW'(1);
        end
      end
      ST_DRAIN: begin
        if (rsp.valid && rsp.ch == ChIdxW'(CHANNELS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.width_ch0 = wv[0];
          out_d.width_ch1 = wv[1];
          out_d.width_ch2 = wv[2];
          out_d.width_ch3 = wv[3];
          out_d.width_ch4 = wv[4];
          out_d.width_ch5 = wv[5];
          out_d.width_ch6 = wv[6];
          out_d.width_ch7 = wv[7];
          out_d.led_on    = led_q;
          out_d.link_lost = pkt_q > timeout_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= DefCommandCode;
      timeout_q   <= DefLinkTimeout;
      period_q    <= DefCtrlPeriod;
      slow_q      <= DefSlowBlink;
      fast_q      <= DefFastBlink;
      pmin_q      <= DefPulseMin;
      pmax_q      <= DefPulseMax;
      fsafe_q     <= DefFailsafe;
      state_q     <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        thrust_q[i] <= ThrustReset;
        pulse_q[i]  <= PulseReset;
      end
      count_q     <= '0;
      fresh_q     <= 1'b0;
      flash_q     <= 1'b0;
      tl_q        <= '0;
      led_q       <= 1'b0;
      pkt_q       <= '0;
      ctrl_q      <= '0;
      tog_q       <= '0;
      issue_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      cmd_q       <= cmd_d;
      timeout_q   <= timeout_d;
      period_q    <= period_d;
      slow_q      <= slow_d;
      fast_q      <= fast_d;
      pmin_q      <= pmin_d;
      pmax_q      <= pmax_d;
      fsafe_q     <= fsafe_d;
      state_q     <= state_d;
      thrust_q    <= thrust_d;
      pulse_q     <= pulse_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      flash_q     <= flash_d;
      tl_q        <= tl_d;
      led_q       <= led_d;
      pkt_q       <= pkt_d;
      ctrl_q      <= ctrl_d;
      tog_q       <= tog_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // packet byte store, valid only for bytes written in the current transaction
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[StW-1:0]] <= in_data_i.data_byte;
    end
  end

  // shared width mapper
  tclw_mapper u_mapper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .pulse_min_i (pmin_q),
    .pulse_max_i (pmax_q),
    .rsp_o       (rsp)
  );

  // mapper results only arrive while a remap is in flight
  a_rsp_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (state_q == ST_MAP || state_q == ST_DRAIN))
    else $error("mapper result outside a remap");

  // a new output beat is only produced from the emit state
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == ST_EMIT))
    else $error("output beat not loaded from emit state");

  // an accepted item always leaves idle
  a_acc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EMIT || state_q == ST_MAP))
    else $error("accepted item did not start processing");

  // issue counter stays inside the channel range
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAP) |-> (issue_q < CntW'(CHANNELS)))
    else $error("channel issue counter out of range");

endmodule
